### rtl/cbts_pkg.sv
// ----------------------------------------------------------------------------
// CAN bit timing search package
// Shared widths, defaults, field constants and the sequencer state type.
// ----------------------------------------------------------------------------
package cbts_pkg;

  // Default search bounds.
  localparam int DEF_MAX_PRESCALE = 15;
  localparam int DEF_MAX_QUANTA   = 32;
  localparam int DEF_MAX_SEGMENTS = 17;

  // Fixed field widths.
  localparam int CLOCK_W    = 32;
  localparam int RATE_W     = 20;
  localparam int PRESC_W    = 4;
  localparam int WORD_W     = 15;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Timing word subfield widths (these act as the field masks).
  localparam int QUANTA_FW = 6;
  localparam int SJW_FW    = 2;
  localparam int SEG1_FW   = 4;
  localparam int SEG2_FW   = 3;

  // Smallest segment total and jump width cap.
  localparam int MIN_SEGMENTS = 3;
  localparam int SJW_CAP      = 3;

  // Main clock frequency after reset.
  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd48000000;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_EMIT
  } state_t;

endpackage

### rtl/cbts_div.sv
// ----------------------------------------------------------------------------
// CAN bit timing search divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cbts_pkg::CLOCK_W-1:0]  dividend,
  input  logic [cbts_pkg::RATE_W-1:0]   divisor,
  output logic                          done,
  output logic [cbts_pkg::CLOCK_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(cbts_pkg::CLOCK_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [cbts_pkg::RATE_W-1:0]   dsr;
  logic [cbts_pkg::RATE_W-1:0]   rem;
  logic [cbts_pkg::CLOCK_W-1:0]  quo;

  logic [cbts_pkg::RATE_W:0]     rem_shift;
  logic [cbts_pkg::RATE_W:0]     diff;
  logic                          fits;

  // One trial subtraction of the shifted partial remainder.
  always_comb begin
    rem_shift = {rem, quo[cbts_pkg::CLOCK_W-1]};
    diff      = rem_shift - {1'b0, dsr};
    fits      = (rem_shift >= {1'b0, dsr});
  end

  // Control: count out one step per quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(cbts_pkg::CLOCK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[cbts_pkg::RATE_W-1:0] : rem_shift[cbts_pkg::RATE_W-1:0];
      quo <= {quo[cbts_pkg::CLOCK_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

### rtl/can_bit_timing_search.sv
// Sequencing: a zero bit rate goes straight to the emit state once the transaction is accepted;
// otherwise the divider runs, then one candidate is checked per cycle, up to 7680
// candidates, and the emit state loads the result when the output register is free.
// Throughput: one item at a time; the next input is accepted no earlier than the cycle
// after the result is loaded into the output register.
// Reset: synchronous, restores the main clock register to 48 MHz and empties the output.
// ----------------------------------------------------------------------------
// CAN bit timing search
// Divides the main clock by the bit rate, then steps incremental adders and
// an equality compare through prescaler, quanta and segment candidates to find the
// first exact match, and packs the timing word.
// ----------------------------------------------------------------------------
module can_bit_timing_search #(
  parameter int MAX_PRESCALE = cbts_pkg::DEF_MAX_PRESCALE,
  parameter int MAX_QUANTA   = cbts_pkg::DEF_MAX_QUANTA,
  parameter int MAX_SEGMENTS = cbts_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Main clock frequency register.
  input  logic                            cfg_we,
  input  logic [cbts_pkg::CLOCK_W-1:0]    cfg_wdata,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cbts_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [19:0] bit_rate
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cbts_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [3:0] prescaler, [18:4] timing_word
  output logic                            m_axis_tuser   // [0] found
);

  localparam int PW     = $clog2(MAX_PRESCALE + 1);
  localparam int QW     = $clog2(MAX_QUANTA + 1);
  localparam int SW     = $clog2(MAX_SEGMENTS + 1);
  localparam int STEPW  = $clog2((MAX_PRESCALE + 1) * MAX_QUANTA + 1);
  localparam int PRODW  = $clog2(MAX_SEGMENTS * MAX_QUANTA * (MAX_PRESCALE + 1) + 1);
  localparam int PAD_W  = cbts_pkg::OUT_DATA_W - cbts_pkg::PRESC_W - cbts_pkg::WORD_W;

  cbts_pkg::state_t state, state_next;

  logic [cbts_pkg::CLOCK_W-1:0] main_clock_hz;
  logic [cbts_pkg::RATE_W-1:0]  bit_rate;
  logic                         in_accept;
  logic                         div_start;
  logic                         div_done;
  logic [cbts_pkg::CLOCK_W-1:0] div_quo;

  logic [cbts_pkg::CLOCK_W-1:0] per_bit;
  logic [PW-1:0]                p;
  logic [QW-1:0]                q;
  logic [SW-1:0]                s;
  logic [STEPW-1:0]             step;
  logic [PRODW-1:0]             prod;
  logic                         found;

  logic                         hit;
  logic                         last_s;
  logic                         last_q;
  logic                         last_p;
  logic [STEPW-1:0]             p_inc;
  logic [STEPW-1:0]             step_q;
  logic [STEPW-1:0]             step_p;
  logic                         out_free;
  logic                         out_load;

  logic [SW-1:0]                r;
  logic [SW-1:0]                seg1;
  logic [SW-1:0]                seg2;
  logic [SW-1:0]                sjw;
  logic [cbts_pkg::WORD_W-1:0]  word;

  logic                         out_valid;
  logic                         out_found;
  logic [cbts_pkg::PRESC_W-1:0] out_presc;
  logic [cbts_pkg::WORD_W-1:0]  out_word;

  assign bit_rate  = s_axis_tdata[cbts_pkg::RATE_W-1:0];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid || m_axis_tready;

  // Main clock frequency register.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_clock_hz <= cbts_pkg::CLOCK_RESET;
    end else if (cfg_we) begin
      main_clock_hz <= cfg_wdata;
    end
  end

  // Single divider for clocks per bit.
  cbts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (main_clock_hz),
    .divisor  (bit_rate),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Candidate compare and the increments for the next candidate.
  always_comb begin
    hit    = (per_bit == cbts_pkg::CLOCK_W'(prod));
    last_s = (s == SW'(MAX_SEGMENTS));
    last_q = (q == QW'(MAX_QUANTA));
    last_p = (p == PW'(MAX_PRESCALE));
    p_inc  = STEPW'(p) + STEPW'(1);
    step_q = step + p_inc;
    step_p = p_inc + STEPW'(1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cbts_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = (bit_rate == '0) ? cbts_pkg::ST_EMIT : cbts_pkg::ST_DIV;
        end
      end
      cbts_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = cbts_pkg::ST_SEARCH;
        end
      end
      cbts_pkg::ST_SEARCH: begin
        if (hit || (last_s && last_q && last_p)) begin
          state_next = cbts_pkg::ST_EMIT;
        end
      end
      cbts_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = cbts_pkg::ST_IDLE;
        end
      end
      default: state_next = cbts_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      cbts_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = s_axis_tvalid && (bit_rate != '0);
      end
      cbts_pkg::ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath: one candidate per cycle through incremental adders.
  always_ff @(posedge clk) begin
    case (state)
      cbts_pkg::ST_IDLE: begin
        found <= 1'b0;
      end
      cbts_pkg::ST_DIV: begin
        per_bit <= div_quo;
        p       <= '0;
        q       <= QW'(1);
        s       <= SW'(cbts_pkg::MIN_SEGMENTS);
        step    <= STEPW'(1);
        prod    <= PRODW'(cbts_pkg::MIN_SEGMENTS);
      end
      cbts_pkg::ST_SEARCH: begin
        if (hit) begin
          found <= 1'b1;
        end else if (!last_s) begin
          s    <= s + SW'(1);
          prod <= prod + PRODW'(step);
        end else if (!last_q) begin
          q    <= q + QW'(1);
          s    <= SW'(cbts_pkg::MIN_SEGMENTS);
          step <= step_q;
          prod <= PRODW'(step_q) + (PRODW'(step_q) << 1);
        end else if (!last_p) begin
          p    <= p + PW'(1);
          q    <= QW'(1);
          s    <= SW'(cbts_pkg::MIN_SEGMENTS);
          step <= step_p;
          prod <= PRODW'(step_p) + (PRODW'(step_p) << 1);
        end
      end
      default: begin
        found <= found;
      end
    endcase
  end

  // Segment split and timing word packing of the match.
  always_comb begin
    r    = s - SW'(cbts_pkg::MIN_SEGMENTS);
    seg1 = r >> 1;
    seg2 = r - seg1;
    sjw  = (seg1 > SW'(cbts_pkg::SJW_CAP)) ? SW'(cbts_pkg::SJW_CAP) : seg1;
    word = {cbts_pkg::SEG2_FW'(seg2), cbts_pkg::SEG1_FW'(seg1),
            cbts_pkg::SJW_FW'(sjw), cbts_pkg::QUANTA_FW'(q - QW'(1))};
  end

  // Output register; it holds one result while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found <= found;
      out_presc <= found ? cbts_pkg::PRESC_W'(p) : '0;
      out_word  <= found ? word : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_found;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_word, out_presc};

endmodule

### tb/can_bit_timing_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing search testbench
// Streams bit rates into the block under several main clock settings. A local
// search model computes the expected prescaler, timing word and found flag for
// every accepted transaction, and each result is checked against it in order.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module can_bit_timing_search_tb;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 11;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_PHASE_ITEMS = 20;

  typedef struct packed {
    logic                         found;
    logic [cbts_pkg::PRESC_W-1:0] prescaler;
    logic [cbts_pkg::WORD_W-1:0]  timing_word;
  } timing_result_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [cbts_pkg::CLOCK_W-1:0]    cfg_wdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [cbts_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // [19:0] bit_rate
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [cbts_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // [3:0] prescaler, [18:4] timing_word
  logic                            m_axis_tuser;   // [0] found

  // Bit rates waiting for the driver, and results expected from the block.
  logic [cbts_pkg::RATE_W-1:0] rate_pending_q[$];
  timing_result_t              timing_expect_q[$];

  // Local copy of the main clock register.
  logic [cbts_pkg::CLOCK_W-1:0] main_clock_copy;

  int     error_count;
  int     rates_issued;
  int     results_seen;
  longint cycle_count;
  logic   in_accepted;

  // Sender burst state and receiver stall pattern.
  int          burst_left;
  int          gap_left;
  logic [15:0] ready_pattern;
  int          pattern_pos;
  int          pattern_age;

  can_bit_timing_search u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Scan prescaler, quanta and segment total in order and return the first
  // exact match of the clocks per bit, packed the way the block reports it.
  function automatic timing_result_t search_bit_timing(
    input logic [cbts_pkg::RATE_W-1:0]  rate,
    input logic [cbts_pkg::CLOCK_W-1:0] clock_hz
  );
    timing_result_t res;
    logic [cbts_pkg::CLOCK_W-1:0] per_bit;
    int unsigned rest;
    int unsigned seg1;
    int unsigned seg2;
    int unsigned sjw;
    bit done;
    res = '0;
    done = 1'b0;
    if (rate == '0) begin
      return res;
    end
    per_bit = clock_hz / {{(cbts_pkg::CLOCK_W-cbts_pkg::RATE_W){1'b0}}, rate};
    for (int unsigned p = 0; p <= cbts_pkg::DEF_MAX_PRESCALE && !done; p++) begin
      for (int unsigned q = 1; q <= cbts_pkg::DEF_MAX_QUANTA && !done; q++) begin
        for (int unsigned s = cbts_pkg::MIN_SEGMENTS;
             s <= cbts_pkg::DEF_MAX_SEGMENTS && !done; s++) begin
          if (per_bit == s * q * (p + 1)) begin
            rest = s - cbts_pkg::MIN_SEGMENTS;
            seg1 = rest / 2;
            seg2 = rest - seg1;
            sjw = (seg1 > cbts_pkg::SJW_CAP) ? cbts_pkg::SJW_CAP : seg1;
            res.found = 1'b1;
            res.prescaler = cbts_pkg::PRESC_W'(p);
            res.timing_word = {cbts_pkg::SEG2_FW'(seg2), cbts_pkg::SEG1_FW'(seg1),
                               cbts_pkg::SJW_FW'(sjw), cbts_pkg::QUANTA_FW'(q - 1)};
            done = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // Pick a bit rate that divides the clock into a reachable product, so most
  // random requests end in a match. Small prescalers are favored.
  function automatic logic [cbts_pkg::RATE_W-1:0] matching_rate(
    input logic [cbts_pkg::CLOCK_W-1:0] clock_hz
  );
    int unsigned p;
    int unsigned q;
    int unsigned s;
    logic [cbts_pkg::CLOCK_W-1:0] rate32;
    for (int tries = 0; tries < 20; tries++) begin
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cbts_pkg::DEF_MAX_PRESCALE)
                                      : $urandom_range(0, 3);
      q = $urandom_range(1, cbts_pkg::DEF_MAX_QUANTA);
      s = $urandom_range(cbts_pkg::MIN_SEGMENTS, cbts_pkg::DEF_MAX_SEGMENTS);
      rate32 = clock_hz / (s * q * (p + 1));
      if (rate32 != '0 && rate32 < (1 << cbts_pkg::RATE_W)) begin
        return rate32[cbts_pkg::RATE_W-1:0];
      end
    end
    return cbts_pkg::RATE_W'($urandom_range(1, (1 << cbts_pkg::RATE_W) - 1));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Wait until every issued rate has produced its result.
  task automatic wait_drained();
    while (rate_pending_q.size() != 0 || results_seen != rates_issued) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_main_clock(input logic [cbts_pkg::CLOCK_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    main_clock_copy = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed requests, the rest random over the whole field.
  task automatic queue_random_rates(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        rate_pending_q.push_back(matching_rate(main_clock_copy));
      end else if ($urandom_range(0, 7) == 0) begin
        rate_pending_q.push_back('0);
      end else begin
        rate_pending_q.push_back(cbts_pkg::RATE_W'($urandom()));
      end
    end
  endtask

  // Input driver: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || in_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (rate_pending_q.size() != 0) begin
        s_axis_tdata <= {{(cbts_pkg::IN_DATA_W-cbts_pkg::RATE_W){1'b0}},
                         rate_pending_q.pop_front()};
        s_axis_tvalid <= 1'b1;
        rates_issued++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: a 16-bit pattern refreshed now and then, sometimes all high.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      pattern_age++;
      if (pattern_age >= 200) begin
        pattern_age = 0;
        ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      end
      pattern_pos = (pattern_pos + 1) % 16;
      m_axis_tready <= ready_pattern[pattern_pos];
    end
  end

  // Record accepted requests and check every result transaction in order.
  always @(posedge clk) begin
    timing_result_t want;
    in_accepted <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        timing_expect_q.push_back(
          search_bit_timing(s_axis_tdata[cbts_pkg::RATE_W-1:0], main_clock_copy));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (timing_expect_q.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          want = timing_expect_q.pop_front();
          if (m_axis_tuser !== want.found) begin
            report_mismatch($sformatf("found %0b, expected %0b", m_axis_tuser, want.found));
          end
          if (m_axis_tdata[cbts_pkg::PRESC_W-1:0] !== want.prescaler) begin
            report_mismatch($sformatf("prescaler %0d, expected %0d",
                                      m_axis_tdata[cbts_pkg::PRESC_W-1:0], want.prescaler));
          end
          if (m_axis_tdata[cbts_pkg::PRESC_W+cbts_pkg::WORD_W-1:cbts_pkg::PRESC_W]
              !== want.timing_word) begin
            report_mismatch($sformatf(
              "timing word 0x%04h, expected 0x%04h",
              m_axis_tdata[cbts_pkg::PRESC_W+cbts_pkg::WORD_W-1:cbts_pkg::PRESC_W],
              want.timing_word));
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [cbts_pkg::CLOCK_W-1:0] clock_plan[$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    in_accepted = 1'b0;
    main_clock_copy = cbts_pkg::CLOCK_RESET;
    error_count = 0;
    rates_issued = 0;
    results_seen = 0;
    cycle_count = 0;
    burst_left = 1;
    gap_left = 0;
    ready_pattern = 16'hFFFF;
    pattern_pos = 0;
    pattern_age = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset clock: zero rate, field extremes, common
    // CAN rates, rates with no exact match and alternating bit patterns.
    rate_pending_q = '{20'd0, 20'd1, 20'hFFFFF, 20'd1000000, 20'd500000, 20'd250000,
                       20'd125000, 20'd100000, 20'd50000, 20'd20000, 20'd10000,
                       20'd33333, 20'd800000, 20'd666666, 20'h80000, 20'h55555,
                       20'hAAAAA, 20'd3, 20'd47};
    wait_drained();

    // A zero clock never matches; a 1 Hz clock matches nothing either.
    write_main_clock('0);
    rate_pending_q = '{20'd1, 20'd1000000, 20'hFFFFF};
    wait_drained();
    write_main_clock(32'd1);
    rate_pending_q = '{20'd1, 20'd0, 20'd2};
    wait_drained();

    // Random phases over several clock settings, the largest among them.
    clock_plan = '{32'hFFFF_FFFF, 32'd8_000_000, 32'($urandom()), 32'd48_000_000};
    foreach (clock_plan[i]) begin
      write_main_clock(clock_plan[i]);
      queue_random_rates(RANDOM_PHASE_ITEMS);
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (timing_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", timing_expect_q.size()));
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
